// ----- rtl/sfr_pkg.sv -----
package sfr_pkg;

  // pattern geometry
  localparam int MAX_PATTERN_BYTES = 8;
  localparam int HOLD_DEPTH        = MAX_PATTERN_BYTES - 1;
  localparam int DATA_W            = 8 * MAX_PATTERN_BYTES;
  localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int HOLD_CNT_W        = $clog2(HOLD_DEPTH + 1);
  localparam int SEL_W             = $clog2(MAX_PATTERN_BYTES);
  localparam int TOTAL_W           = 16;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FIND_PATTERN    = 2'd0,
    REG_FIND_LENGTH     = 2'd1,
    REG_REPLACE_PATTERN = 2'd2,
    REG_REPLACE_LENGTH  = 2'd3
  } cfg_reg_t;

  // one unit of output work: count beats taken from data, lowest byte first
  typedef struct packed {
    logic               has_bytes;
    logic [DATA_W-1:0]  data;
    logic [LEN_W-1:0]   count;
    logic [TOTAL_W-1:0] total;
  } job_t;

endpackage

// ----- rtl/sfr_front.sv -----
module sfr_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  logic [7:0]              in_byte,
  input  logic                    end_of_stream,
  input  logic                    cfg_write,
  input  sfr_pkg::cfg_reg_t       cfg_index,
  input  logic [63:0]             cfg_data,
  output logic                    push,
  output sfr_pkg::job_t           job
);
  import sfr_pkg::*;

  logic [DATA_W-1:0]     find_pattern;
  logic [LEN_W-1:0]      find_length;
  logic [DATA_W-1:0]     replace_pattern;
  logic [LEN_W-1:0]      replace_length;

  logic [7:0]            held [HOLD_DEPTH];
  logic [7:0]            held_next [HOLD_DEPTH];
  logic [HOLD_CNT_W-1:0] held_count;
  logic [HOLD_CNT_W-1:0] held_count_next;
  logic [TOTAL_W-1:0]    match_counter;
  logic [TOTAL_W-1:0]    match_counter_next;

  logic [LEN_W-1:0]      flen;
  logic [LEN_W-1:0]      rlen;
  logic [LEN_W-1:0]      hc_inc;
  logic [HOLD_CNT_W-1:0] tail_idx;
  logic [7:0]            win [MAX_PATTERN_BYTES];
  logic                  hit;
  logic [TOTAL_W-1:0]    counter_inc;
  logic [DATA_W-1:0]     held_packed;
  logic [7:0]            shifted [HOLD_DEPTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      find_pattern    <= '0;
      find_length     <= LEN_W'(1);
      replace_pattern <= '0;
      replace_length  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FIND_PATTERN:    find_pattern    <= cfg_data[DATA_W-1:0];
        REG_FIND_LENGTH:     find_length     <= cfg_data[LEN_W-1:0];
        REG_REPLACE_PATTERN: replace_pattern <= cfg_data[DATA_W-1:0];
        REG_REPLACE_LENGTH:  replace_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective lengths, clamped
  always_comb begin
    flen = find_length;
    if (find_length == '0) flen = LEN_W'(1);
    if (find_length > LEN_W'(MAX_PATTERN_BYTES)) flen = LEN_W'(MAX_PATTERN_BYTES);
    rlen = replace_length;
    if (replace_length > LEN_W'(MAX_PATTERN_BYTES)) rlen = LEN_W'(MAX_PATTERN_BYTES);
  end

  // window compare: held bytes then the incoming byte
  always_comb begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      win[i] = (HOLD_CNT_W'(i) < held_count) ? held[i] : in_byte;
    end
    win[MAX_PATTERN_BYTES-1] = in_byte;
    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (LEN_W'(i) < flen && win[i] != find_pattern[i*8 +: 8]) hit = 1'b0;
    end
  end

  // helpers: window shifted by one with new byte appended, packed view
  always_comb begin
    tail_idx = held_count - HOLD_CNT_W'(1);
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      shifted[i] = (i + 1 < HOLD_DEPTH) ? held[(i + 1) % HOLD_DEPTH] : 8'h00;
      if (HOLD_CNT_W'(i) == tail_idx) shifted[i] = in_byte;
    end
    held_packed = '0;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      held_packed[i*8 +: 8] = held[i];
    end
    hc_inc      = LEN_W'(held_count) + LEN_W'(1);
    counter_inc = (match_counter == '1) ? match_counter : match_counter + TOTAL_W'(1);
  end

  // classify the item and update the window
  always_comb begin
    held_next          = held;
    held_count_next    = held_count;
    match_counter_next = match_counter;
    push               = 1'b0;
    job.has_bytes      = 1'b1;
    job.data           = {{(DATA_W-8){1'b0}}, held[0]};
    job.count          = LEN_W'(1);
    job.total          = match_counter;
    if (fire) begin
      if (end_of_stream) begin
        // flush held bytes, or one bare count beat
        push               = 1'b1;
        job.has_bytes      = (held_count != '0);
        job.data           = (held_count != '0) ? held_packed : '0;
        job.count          = (held_count != '0) ? LEN_W'(held_count) : LEN_W'(1);
        held_count_next    = '0;
        match_counter_next = '0;
      end else if (hc_inc > flen) begin
        // window longer than pattern: release oldest, no compare
        push      = 1'b1;
        held_next = shifted;
      end else if (hc_inc < flen) begin
        // still filling the window
        for (int i = 0; i < HOLD_DEPTH; i++) begin
          if (HOLD_CNT_W'(i) == held_count) held_next[i] = in_byte;
        end
        held_count_next = held_count + HOLD_CNT_W'(1);
      end else if (hit) begin
        // match: drop window, emit replacement
        match_counter_next = counter_inc;
        held_count_next    = '0;
        push               = (rlen != '0);
        job.data           = replace_pattern;
        job.count          = rlen;
        job.total          = counter_inc;
      end else if (held_count == '0) begin
        // single byte pattern miss
        push     = 1'b1;
        job.data = {{(DATA_W-8){1'b0}}, in_byte};
      end else begin
        // miss: release oldest, slide window
        push      = 1'b1;
        held_next = shifted;
      end
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      match_counter <= '0;
    end else begin
      held_count    <= held_count_next;
      match_counter <= match_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
  end

endmodule

// ----- rtl/sfr_queue.sv -----
module sfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::job_t push_job,
  input  logic          pop,
  output sfr_pkg::job_t head_job,
  output logic          empty,
  output logic          full
);
  import sfr_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign empty    = (fill == '0);
  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head_job = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= QPTR_W'((int'(wr_ptr) + 1) % QUEUE_DEPTH);
      if (pop)  rd_ptr <= QPTR_W'((int'(rd_ptr) + 1) % QUEUE_DEPTH);
      if (push && !pop) fill <= fill + QCNT_W'(1);
      else if (pop && !push) fill <= fill - QCNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

// ----- rtl/sfr_back.sv -----
module sfr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sfr_pkg::job_t               head_job,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic [sfr_pkg::TOTAL_W-1:0] match_total,
  output logic                        last
);
  import sfr_pkg::*;

  logic [SEL_W-1:0] idx;
  logic             load;
  logic             job_done;

  // output register free or being taken this cycle
  assign load     = !empty && (!out_valid || !out_stall);
  assign job_done = (LEN_W'(idx) + LEN_W'(1)) == head_job.count;
  assign pop      = load && job_done;

  // beat index within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) idx <= job_done ? '0 : idx + SEL_W'(1);
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head_job.has_bytes ? head_job.data[idx*8 +: 8] : 8'h00;
      byte_valid  <= head_job.has_bytes;
      match_total <= head_job.total;
      last        <= job_done;
    end
  end

endmodule

// ----- rtl/stream_find_replace.sv -----
// an accepted item's job is queued, then its beats load the output beat register
// throughput: one input item per cycle unless in_stall, one output beat per cycle
//   unless out_stall; a k-beat item holds the output, a four-job queue absorbs bursts
// in_stall rises only while the job queue is full
// reset (rst, synchronous, active high) empties window, queue and output, clears the
//   match count and loads register defaults: find length 1, everything else zero
module stream_find_replace (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        end_of_stream,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic [sfr_pkg::TOTAL_W-1:0] match_total,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  sfr_pkg::cfg_reg_t           cfg_index,
  input  logic [63:0]                 cfg_data
);
  import sfr_pkg::*;

  logic fire;
  logic push;
  logic pop;
  logic empty;
  logic full;
  job_t push_job;
  job_t head_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign fire      = in_valid && !in_stall;

  // classify and track the window
  sfr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .job           (push_job)
  );

  // job queue
  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty),
    .full     (full)
  );

  // beat generation
  sfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .match_total (match_total),
    .last        (last)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sfr_pkg::*;

  // one output beat as the predictor expects it
  typedef struct {
    logic [7:0]         data;
    logic               has_byte;
    logic [TOTAL_W-1:0] total;
    logic               tail;
  } beat_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte       = 8'h00;
  logic               end_of_stream = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [7:0]         out_byte;
  logic               byte_valid;
  logic [TOTAL_W-1:0] match_total;
  logic               last;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  cfg_reg_t           cfg_index     = REG_FIND_PATTERN;
  logic [63:0]        cfg_data      = '0;

  stream_find_replace dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .match_total   (match_total),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // register copies, at their reset values
  logic [63:0] find_pat     = '0;
  logic [3:0]  find_len_reg = 4'd1;
  logic [63:0] repl_pat     = '0;
  logic [3:0]  repl_len_reg = 4'd0;

  // window and match count of the predictor
  logic [7:0]         window [HOLD_DEPTH];
  int                 held     = 0;
  logic [TOTAL_W-1:0] replaced = '0;
  beat_t              expected_beats [$];

  int idle_pct    = 0;
  int stall_pct   = 0;
  int items_sent  = 0;
  int beats_seen  = 0;
  int cfg_writes  = 0;
  int error_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function automatic int eff_find_len();
    if (find_len_reg == 4'd0) return 1;
    if (find_len_reg > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
    return find_len_reg;
  endfunction

  function automatic int eff_repl_len();
    if (repl_len_reg > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
    return repl_len_reg;
  endfunction

  function automatic void clear_window();
    foreach (window[i]) window[i] = 8'h00;
    held = 0;
  endfunction

  function automatic void push_beat(logic [7:0] d, logic v, logic t);
    beat_t b;
    b.data     = d;
    b.has_byte = v;
    b.total    = replaced;
    b.tail     = t;
    expected_beats.push_back(b);
  endfunction

  function automatic logic [7:0] release_oldest();
    logic [7:0] oldest;
    oldest = window[0];
    for (int i = 0; i < HOLD_DEPTH - 1; i++) window[i] = window[i + 1];
    window[HOLD_DEPTH - 1] = 8'h00;
    if (held > 0) held--;
    return oldest;
  endfunction

  function automatic void shift_in(logic [7:0] b);
    if (held < HOLD_DEPTH) begin
      window[held] = b;
      held++;
    end
  endfunction

  // expected beats for one accepted input beat
  function automatic void predict_item(logic [7:0] b, logic eos);
    int   flen;
    int   rlen;
    logic hit;
    logic [7:0] w;
    flen = eff_find_len();
    // end of stream: flush the window, or a bare count beat
    if (eos) begin
      if (held == 0) push_beat(8'h00, 1'b0, 1'b1);
      for (int i = 0; i < held; i++) push_beat(window[i], 1'b1, i + 1 == held);
      clear_window();
      replaced = '0;
      return;
    end
    // window longer than the pattern: drain oldest, no compare
    if (held + 1 > flen) begin
      push_beat(release_oldest(), 1'b1, 1'b1);
      shift_in(b);
      return;
    end
    // still filling the window
    if (held + 1 < flen) begin
      shift_in(b);
      return;
    end
    hit = 1'b1;
    for (int i = 0; i < flen; i++) begin
      w = (i < held) ? window[i] : b;
      if (w != find_pat[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      rlen = eff_repl_len();
      if (replaced != '1) replaced++;
      clear_window();
      for (int i = 0; i < rlen; i++) push_beat(repl_pat[8*i +: 8], 1'b1, i + 1 == rlen);
      return;
    end
    if (held == 0) begin
      push_beat(b, 1'b1, 1'b1);
    end else begin
      push_beat(release_oldest(), 1'b1, 1'b1);
      shift_in(b);
    end
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_item(logic [7:0] b, logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    predict_item(b, eos);
    items_sent++;
  endtask

  // drop valid, wait for outstanding beats, then let the pipeline drain
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_beats.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FIND_PATTERN:    find_pat     = val;
      REG_FIND_LENGTH:     find_len_reg = val[3:0];
      REG_REPLACE_PATTERN: repl_pat     = val;
      REG_REPLACE_LENGTH:  repl_len_reg = val[3:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(logic [63:0] fp, logic [3:0] fl, logic [63:0] rp, logic [3:0] rl);
    settle();
    write_reg(REG_FIND_PATTERN, fp);
    write_reg(REG_FIND_LENGTH, {60'd0, fl});
    write_reg(REG_REPLACE_PATTERN, rp);
    write_reg(REG_REPLACE_LENGTH, {60'd0, rl});
    cfg_valid <= 1'b0;
  endtask

  // register defaults: a zero byte is the pattern and gets deleted
  task automatic test_reset_defaults();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // two byte pattern, longer replacement, flush and bare end
  task automatic test_basic_replace();
    set_config(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  // lengths beyond eight clip to eight, find length zero acts as one
  task automatic test_length_limits();
    set_config('1, 4'd15, 64'h8877665544332211, 4'd15);
    repeat (8) send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    set_config(64'hA5A5_A5A5_A5A5_A500, 4'd0, 64'h7F, 4'd8);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b1);
  endtask

  // shrink the find length while bytes are held
  task automatic test_window_shrink();
    set_config(64'h05_0403_0201, 4'd5, 64'hEE, 4'd1);
    send_item(8'h01, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'h03, 1'b0);
    send_item(8'h04, 1'b0);
    set_config(64'h0605, 4'd2, 64'hEEDD, 4'd2);
    send_item(8'h05, 1'b0);
    send_item(8'h06, 1'b0);
    send_item(8'h07, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // mostly pattern runs with random content, plus broken runs and noise
  task automatic test_random_traffic(int in_idle, int out_busy, int n_items);
    logic [7:0]  alpha [2];
    logic [63:0] fp;
    logic [3:0]  fl;
    logic [3:0]  rl;
    int          start;
    int          flen;
    int          pick;
    int          cut;
    idle_pct  = in_idle;
    stall_pct = out_busy;
    for (int s = 0; s < 2; s++) begin
      alpha[0] = 8'($urandom);
      alpha[1] = 8'($urandom);
      fp = {$urandom, $urandom};
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(3) != 0) fp[8*i +: 8] = alpha[$urandom_range(1)];
      end
      pick = $urandom_range(9);
      fl = (pick == 0) ? 4'd0 : (pick == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
      rl = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      set_config(fp, fl, {$urandom, $urandom}, rl);
      flen  = eff_find_len();
      start = items_sent;
      while (items_sent - start < n_items) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          cut = (pick < 52 || flen == 1) ? flen : $urandom_range(1, flen - 1);
          for (int i = 0; i < cut; i++) send_item(fp[8*i +: 8], 1'b0);
        end else if (pick < 86) begin
          send_item(alpha[$urandom_range(1)], 1'b0);
        end else if (pick < 95) begin
          send_item(8'($urandom), 1'b0);
        end else begin
          send_item(8'($urandom), 1'b1);
        end
      end
      // sometimes leave bytes held across the next register change
      if ($urandom_range(1) == 1) send_item(8'($urandom), 1'b1);
    end
  endtask

  // count rises with each deleted match, then clears at end of stream
  task automatic test_count_clear();
    idle_pct  = 0;
    stall_pct = 0;
    set_config(64'h3C, 4'd1, 64'h0, 4'd0);
    repeat (12) send_item(8'h3C, 1'b0);
    send_item(8'h11, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h3C, 1'b0);
    send_item(8'h3C, 1'b1);
  endtask

  // compare each accepted output beat with the oldest expectation
  initial begin : beat_checker
    beat_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          report_error($sformatf("unexpected beat: byte %02h valid %0b total %0d last %0b",
                                 out_byte, byte_valid, match_total, last));
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.data || byte_valid !== want.has_byte ||
              match_total !== want.total || last !== want.tail) begin
            report_error($sformatf(
              "beat %0d: expected byte %02h valid %0b total %0d last %0b, got %02h %0b %0d %0b",
              beats_seen, want.data, want.has_byte, want.total, want.tail,
              out_byte, byte_valid, match_total, last));
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // test sequence
  initial begin
    clear_window();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_basic_replace();
    test_length_limits();
    test_window_shrink();
    test_random_traffic(0, 0, 28);
    test_random_traffic(50, 0, 28);
    test_random_traffic(0, 50, 28);
    test_random_traffic(24, 24, 28);
    test_count_clear();
    stall_pct = 0;
    settle();
    repeat (20) @(posedge clk);
    if (expected_beats.size() != 0)
      report_error($sformatf("%0d expected beats never arrived", expected_beats.size()));
    $display("summary: %0d input beats, %0d output beats, %0d register writes, %0d errors",
             items_sent, beats_seen, cfg_writes, error_count);
    $display("summary: directed limits, window shrink, match count and clear, four idle/stall mixes");
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
